// ===== sv/bc_pkg.sv =====
package bc_pkg;

    localparam int COORD_BITS       = 16;
    localparam int WEIGHT_FRAC_BITS = 14;
    localparam int OUT_BITS         = 16;

    localparam int EW  = COORD_BITS + 1;
    localparam int PW  = 2 * EW;
    localparam int DW  = PW + 2;
    localparam int LW  = DW / 2;
    localparam int HW  = DW - LW;
    localparam int MW  = 2 * DW;
    localparam int NW  = MW + 2;
    localparam int QB  = OUT_BITS + 1;
    localparam int CW  = NW + WEIGHT_FRAC_BITS + QB + 1;

    localparam logic [QB:0] POS_LIMIT = (QB+1)'((1 << (OUT_BITS - 1)) - 1);
    localparam logic [QB:0] NEG_LIMIT = (QB+1)'(1 << (OUT_BITS - 1));

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] az;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] bz;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pz;
    } t_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] weight_u;
        logic signed [OUT_BITS-1:0] weight_v;
        logic signed [OUT_BITS-1:0] weight_w;
        logic                       degenerate;
    } t_out;

    typedef struct packed {
        logic signed [DW-1:0] d00;
        logic signed [DW-1:0] d01;
        logic signed [DW-1:0] d11;
        logic signed [DW-1:0] d20;
        logic signed [DW-1:0] d21;
    } t_dots;

endpackage

// ===== sv/barycentric_coordinates.sv =====
// channel   signals                              direction
// in        i_in_valid  o_in_ready  i_in_data    request in: vertices a, b, c and point p
// out       o_out_valid i_out_ready o_out_data   request out: weights u, v, w, degenerate
//
// one request per cycle unless the output stalls; stages in order: dot products, wide
// multipliers, numerator and determinant, 17-step restoring divider with rounding
// synchronous active-low reset clears only the valid bits of every stage
// the whole pipeline advances together whenever the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated
module barycentric_coordinates
    import bc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic                 w_en;
    logic                 w_dot_vld;
    t_dots                w_dots;

    logic signed [MW-1:0] w_p00_11;
    logic signed [MW-1:0] w_p01_01;
    logic signed [MW-1:0] w_p11_20;
    logic signed [MW-1:0] w_p01_21;
    logic signed [MW-1:0] w_p00_21;
    logic signed [MW-1:0] w_p01_20;
    logic [1:0]           r_mvld;

    logic signed [NW-1:0] w_den;
    logic                 r_s6_vld;
    logic                 r_s6_zero;
    logic signed [NW-1:0] r_s6_den;
    logic signed [NW-1:0] r_s6_nv;
    logic signed [NW-1:0] r_s6_nw;

    logic                 r_s7_vld;
    logic                 r_s7_zero;
    logic signed [NW-1:0] r_s7_den;
    logic signed [NW-1:0] r_s7_nu;
    logic signed [NW-1:0] r_s7_nv;
    logic signed [NW-1:0] r_s7_nw;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    bc_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (w_dot_vld),
        .o_dots  (w_dots)
    );

    bc_mul u_mul0 (.i_clk(i_clk), .i_en(w_en), .i_a(w_dots.d00), .i_b(w_dots.d11), .o_p(w_p00_11));
    bc_mul u_mul1 (.i_clk(i_clk), .i_en(w_en), .i_a(w_dots.d01), .i_b(w_dots.d01), .o_p(w_p01_01));
    bc_mul u_mul2 (.i_clk(i_clk), .i_en(w_en), .i_a(w_dots.d11), .i_b(w_dots.d20), .o_p(w_p11_20));
    bc_mul u_mul3 (.i_clk(i_clk), .i_en(w_en), .i_a(w_dots.d01), .i_b(w_dots.d21), .o_p(w_p01_21));
    bc_mul u_mul4 (.i_clk(i_clk), .i_en(w_en), .i_a(w_dots.d00), .i_b(w_dots.d21), .o_p(w_p00_21));
    bc_mul u_mul5 (.i_clk(i_clk), .i_en(w_en), .i_a(w_dots.d01), .i_b(w_dots.d20), .o_p(w_p01_20));

    assign w_den = NW'(w_p00_11) - NW'(w_p01_01);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld   <= '0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
        end else if (w_en) begin
            r_mvld   <= {r_mvld[0], w_dot_vld};
            r_s6_vld <= r_mvld[1];
            r_s7_vld <= r_s6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_den  <= w_den;
            r_s6_zero <= w_den[NW-1] || (w_den == '0);
            r_s6_nv   <= NW'(w_p11_20) - NW'(w_p01_21);
            r_s6_nw   <= NW'(w_p00_21) - NW'(w_p01_20);
            r_s7_zero <= r_s6_zero;
            r_s7_den  <= r_s6_den;
            r_s7_nu   <= r_s6_den - r_s6_nv - r_s6_nw;
            r_s7_nv   <= r_s6_nv;
            r_s7_nw   <= r_s6_nw;
        end
    end

    bc_div u_div_u (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_s7_vld),
        .i_zero   (r_s7_zero),
        .i_num    (r_s7_nu),
        .i_den    (r_s7_den),
        .o_valid  (o_out_valid),
        .o_zero   (o_out_data.degenerate),
        .o_weight (o_out_data.weight_u)
    );

    bc_div u_div_v (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_s7_vld),
        .i_zero   (r_s7_zero),
        .i_num    (r_s7_nv),
        .i_den    (r_s7_den),
        .o_valid  (),
        .o_zero   (),
        .o_weight (o_out_data.weight_v)
    );

    bc_div u_div_w (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_s7_vld),
        .i_zero   (r_s7_zero),
        .i_num    (r_s7_nw),
        .i_den    (r_s7_den),
        .o_valid  (),
        .o_zero   (),
        .o_weight (o_out_data.weight_w)
    );

endmodule

// ===== sv/bc_dot.sv =====
module bc_dot
    import bc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_in   i_data,
    output logic  o_valid,
    output t_dots o_dots
);

    logic signed [COORD_BITS-1:0] w_a [3];
    logic signed [COORD_BITS-1:0] w_b [3];
    logic signed [COORD_BITS-1:0] w_c [3];
    logic signed [COORD_BITS-1:0] w_p [3];

    logic signed [EW-1:0] r_e0 [3];
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];

    logic signed [PW-1:0] r_p00 [3];
    logic signed [PW-1:0] r_p01 [3];
    logic signed [PW-1:0] r_p11 [3];
    logic signed [PW-1:0] r_p20 [3];
    logic signed [PW-1:0] r_p21 [3];

    logic [2:0] r_vld;

    assign w_a[0] = i_data.ax;
    assign w_a[1] = i_data.ay;
    assign w_a[2] = i_data.az;
    assign w_b[0] = i_data.bx;
    assign w_b[1] = i_data.by;
    assign w_b[2] = i_data.bz;
    assign w_c[0] = i_data.cx;
    assign w_c[1] = i_data.cy;
    assign w_c[2] = i_data.cz;
    assign w_p[0] = i_data.px;
    assign w_p[1] = i_data.py;
    assign w_p[2] = i_data.pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_e0[k] <= EW'(w_b[k]) - EW'(w_a[k]);
                r_e1[k] <= EW'(w_c[k]) - EW'(w_a[k]);
                r_e2[k] <= EW'(w_p[k]) - EW'(w_a[k]);
                r_p00[k] <= PW'(r_e0[k]) * PW'(r_e0[k]);
                r_p01[k] <= PW'(r_e0[k]) * PW'(r_e1[k]);
                r_p11[k] <= PW'(r_e1[k]) * PW'(r_e1[k]);
                r_p20[k] <= PW'(r_e2[k]) * PW'(r_e0[k]);
                r_p21[k] <= PW'(r_e2[k]) * PW'(r_e1[k]);
            end
            o_dots.d00 <= DW'(r_p00[0]) + DW'(r_p00[1]) + DW'(r_p00[2]);
            o_dots.d01 <= DW'(r_p01[0]) + DW'(r_p01[1]) + DW'(r_p01[2]);
            o_dots.d11 <= DW'(r_p11[0]) + DW'(r_p11[1]) + DW'(r_p11[2]);
            o_dots.d20 <= DW'(r_p20[0]) + DW'(r_p20[1]) + DW'(r_p20[2]);
            o_dots.d21 <= DW'(r_p21[0]) + DW'(r_p21[1]) + DW'(r_p21[2]);
        end
    end

    assign o_valid = r_vld[2];

endmodule

// ===== sv/bc_mul.sv =====
module bc_mul
    import bc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    output logic signed [MW-1:0] o_p
);

    logic signed [LW:0]      w_al;
    logic signed [LW:0]      w_bl;
    logic signed [HW-1:0]    w_ah;
    logic signed [HW-1:0]    w_bh;

    logic signed [2*LW+1:0]  r_ll;
    logic signed [LW+HW:0]   r_lh;
    logic signed [LW+HW:0]   r_hl;
    logic signed [2*HW-1:0]  r_hh;

    assign w_al = $signed({1'b0, i_a[LW-1:0]});
    assign w_bl = $signed({1'b0, i_b[LW-1:0]});
    assign w_ah = i_a[DW-1:LW];
    assign w_bh = i_b[DW-1:LW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= (2*LW+2)'(w_al) * (2*LW+2)'(w_bl);
            r_lh <= (LW+HW+1)'(w_al) * (LW+HW+1)'(w_bh);
            r_hl <= (LW+HW+1)'(w_ah) * (LW+HW+1)'(w_bl);
            r_hh <= (2*HW)'(w_ah) * (2*HW)'(w_bh);
            o_p  <= (MW'(r_hh) <<< (2*LW)) + ((MW'(r_lh) + MW'(r_hl)) <<< LW) + MW'(r_ll);
        end
    end

endmodule

// ===== sv/bc_div.sv =====
module bc_div
    import bc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic                       i_zero,
    input  logic signed [NW-1:0]       i_num,
    input  logic signed [NW-1:0]       i_den,
    output logic                       o_valid,
    output logic                       o_zero,
    output logic signed [OUT_BITS-1:0] o_weight
);

    logic          r_av;
    logic          r_aneg;
    logic          r_azero;
    logic [NW-1:0] r_amag;
    logic [NW-1:0] r_aden;

    logic [CW-1:0] r_rem  [QB+1];
    logic [QB-1:0] r_q    [QB+1];
    logic [NW-1:0] r_den  [QB+1];
    logic          r_neg  [QB+1];
    logic          r_ovf  [QB+1];
    logic          r_zero [QB+1];
    logic          r_vld  [QB+1];

    logic [QB:0]   w_qr;
    logic [QB:0]   w_limit;
    logic [QB:0]   w_mag;
    logic          w_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av     <= 1'b0;
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_av     <= i_valid;
            r_vld[0] <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_aneg    <= i_num[NW-1];
            r_azero   <= i_zero;
            r_amag    <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_aden    <= NW'(i_den);
            r_rem[0]  <= CW'(r_amag) << WEIGHT_FRAC_BITS;
            r_ovf[0]  <= (CW'(r_amag) << WEIGHT_FRAC_BITS) >= (CW'(r_aden) << QB);
            r_q[0]    <= '0;
            r_den[0]  <= r_aden;
            r_neg[0]  <= r_aneg;
            r_zero[0] <= r_azero;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        logic [CW:0]   w_diff;
        logic [QB-1:0] n_q;

        assign w_diff = {1'b0, r_rem[j]} - ((CW+1)'(r_den[j]) << (QB - 1 - j));

        always_comb begin
            n_q = r_q[j];
            n_q[QB-1-j] = !w_diff[CW];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= w_diff[CW] ? r_rem[j] : w_diff[CW-1:0];
                r_q[j+1]    <= n_q;
                r_den[j+1]  <= r_den[j];
                r_neg[j+1]  <= r_neg[j];
                r_ovf[j+1]  <= r_ovf[j];
                r_zero[j+1] <= r_zero[j];
            end
        end
    end

    // round half away from zero on the magnitude, then saturate
    assign w_up    = {r_rem[QB][NW-1:0], 1'b0} >= {1'b0, r_den[QB]};
    assign w_qr    = (QB+1)'(r_q[QB]) + (QB+1)'(w_up);
    assign w_limit = r_neg[QB] ? NEG_LIMIT : POS_LIMIT;
    assign w_mag   = (r_ovf[QB] || w_qr > w_limit) ? w_limit : w_qr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_zero <= r_zero[QB];
            if (r_zero[QB]) begin
                o_weight <= '0;
            end else if (r_neg[QB]) begin
                o_weight <= OUT_BITS'(-w_mag);
            end else begin
                o_weight <= OUT_BITS'(w_mag);
            end
        end
    end

endmodule

// ===== sv/bc_checker.sv =====
module bc_checker
    import bc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output request changed while stalled");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.degenerate |->
            o_out_data.weight_u == '0 && o_out_data.weight_v == '0 &&
            o_out_data.weight_w == '0)
        else $error("degenerate result with nonzero weights");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind barycentric_coordinates bc_checker u_bc_checker (.*);

// ===== tb/barycentric_coordinates_checker.sv =====
module barycentric_coordinates_checker
    import bc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_ready,
    input  t_in    i_in_data,
    input  logic   i_out_valid,
    input  logic   i_out_ready,
    input  t_out   i_out_data,
    output int     o_errors,
    output int     o_pending
);

    t_out weights_due[$];
    int   n_errors;

    assign o_errors  = n_errors;
    assign o_pending = weights_due.size();

    function automatic logic signed [15:0] round_weight(
        input logic signed [127:0] num, input logic signed [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        logic [127:0] r;
        logic         neg;
        logic [127:0] lim;
        begin
            neg = num < 0;
            mag = neg ? -num : num;
            mag = mag << WEIGHT_FRAC_BITS;
            q = mag / den;
            r = mag % den;
            if ((r << 1) >= den) q = q + 1;
            lim = neg ? 128'd32768 : 128'd32767;
            if (q > lim) q = lim;
            round_weight = neg ? -q[15:0] : q[15:0];
        end
    endfunction

    function automatic t_out solve_weights(input t_in req);
        logic signed [63:0]  a [3];
        logic signed [63:0]  e0 [3];
        logic signed [63:0]  e1 [3];
        logic signed [63:0]  e2 [3];
        logic signed [63:0]  d00, d01, d11, d20, d21;
        logic signed [127:0] den, nv, nw, nu;
        t_out res;
        begin
            a[0] = req.ax; a[1] = req.ay; a[2] = req.az;
            e0[0] = req.bx - a[0]; e0[1] = req.by - a[1]; e0[2] = req.bz - a[2];
            e1[0] = req.cx - a[0]; e1[1] = req.cy - a[1]; e1[2] = req.cz - a[2];
            e2[0] = req.px - a[0]; e2[1] = req.py - a[1]; e2[2] = req.pz - a[2];
            d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
            for (int k = 0; k < 3; k++) begin
                d00 += e0[k] * e0[k];
                d01 += e0[k] * e1[k];
                d11 += e1[k] * e1[k];
                d20 += e2[k] * e0[k];
                d21 += e2[k] * e1[k];
            end
            den = 128'(d00) * 128'(d11) - 128'(d01) * 128'(d01);
            res = '0;
            if (den <= 0) begin
                res.degenerate = 1'b1;
            end else begin
                nv = 128'(d11) * 128'(d20) - 128'(d01) * 128'(d21);
                nw = 128'(d00) * 128'(d21) - 128'(d01) * 128'(d20);
                nu = den - nv - nw;
                res.weight_u = round_weight(nu, den);
                res.weight_v = round_weight(nv, den);
                res.weight_w = round_weight(nw, den);
            end
            solve_weights = res;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    initial n_errors = 0;

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) weights_due.push_back(solve_weights(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (weights_due.size() == 0) begin
                    report_mismatch("unexpected request", 1, 0);
                end else begin
                    want = weights_due.pop_front();
                    if (i_out_data.weight_u !== want.weight_u)
                        report_mismatch("weight_u", i_out_data.weight_u, want.weight_u);
                    if (i_out_data.weight_v !== want.weight_v)
                        report_mismatch("weight_v", i_out_data.weight_v, want.weight_v);
                    if (i_out_data.weight_w !== want.weight_w)
                        report_mismatch("weight_w", i_out_data.weight_w, want.weight_w);
                    if (i_out_data.degenerate !== want.degenerate)
                        report_mismatch("degenerate", i_out_data.degenerate,
                            want.degenerate);
                end
            end
        end
    end

endmodule

// ===== tb/barycentric_coordinates_tb.sv =====
module barycentric_coordinates_tb;
    import bc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;
    int   n_errors;
    int   n_pending;
    bit   hold_sink;
    bit   sending_done;

    barycentric_coordinates uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    barycentric_coordinates_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_data(o_out_data),
        .o_errors(n_errors), .o_pending(n_pending)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) gap_len = $urandom_range(10, 40);
        else if ($urandom_range(0, 2) == 0) gap_len = $urandom_range(1, 3);
        else gap_len = 0;
    endfunction

    function automatic logic [15:0] pick_coord(input int mode);
        case (mode)
            0: pick_coord = 16'h8000;
            1: pick_coord = 16'h7fff;
            2: pick_coord = 16'($signed($urandom_range(0, 200)) - 100);
            default: pick_coord = 16'($urandom);
        endcase
    endfunction

    // offer one request and wait until it is taken
    task automatic send_request(input t_in req);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_gap();
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every result is back
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls, plus one long hold-off
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_sink) begin
                i_out_ready <= 1'b0;
                repeat (80) @(posedge i_clk);
                hold_sink = 0;
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            if (!sending_done && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge i_clk);
            end
        end
    end

    initial begin
        #4000000;
        $display("barycentric_coordinates regression: fail");
        $finish;
    end

    initial begin
        t_in req;
        int  wait_cycles;
        hold_sink    = 0;
        sending_done = 0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, degenerate, vertex hits, saturation
        req = '0; send_request(req);
        req = '1; send_request(req);
        req = {12{16'h8000}}; send_request(req);
        req = {12{16'h7fff}}; send_request(req);
        req = '0; req.bx = 16'h0010; req.cy = 16'h0010; send_request(req);
        req.px = 16'h0010; send_request(req);
        req.px = 16'h0000; req.py = 16'h0010; send_request(req);
        req.px = 16'h0008; req.py = 16'h0008; send_request(req);
        req.px = 16'h7fff; req.py = 16'h7fff; req.pz = 16'h7fff; send_request(req);
        req.px = 16'h8000; req.py = 16'h8000; req.pz = 16'h8000; send_request(req);
        req = '0; req.ax = 16'h8000; req.ay = 16'h8000; req.az = 16'h8000;
        req.bx = 16'h7fff; req.cy = 16'h7fff; req.cz = 16'h7fff;
        req.px = 16'h7fff; req.py = 16'h8000; send_request(req);
        req = '0; req.bx = 16'h0010; req.cx = 16'h0020; req.px = 16'h0005; send_request(req);
        req = '0; req.bx = 16'h0001; req.cy = 16'h0001; req.px = 16'h7fff; send_request(req);
        req.px = 16'h8000; send_request(req);
        req = '0; req.bx = 16'h7fff; req.by = 16'h0001; req.cx = 16'h7fff;
        req.cy = 16'h0002; req.pz = 16'h1234; send_request(req);

        // wait for all results before random traffic
        wait_drain();

        hold_sink = 1;
        for (int n = 0; n < 450; n++) begin
            for (int f = 0; f < 12; f++) begin
                req[16*f +: 16] = pick_coord($urandom_range(0, 15) < 2 ?
                    $urandom_range(0, 1) : $urandom_range(2, 3));
            end
            if ($urandom_range(0, 15) == 0) req[143:96] = req[191:144];
            send_request(req);
            if (n > 40) send_gap();
            if (n == 200) wait_drain();
        end
        i_in_valid <= 1'b0;
        sending_done = 1;

        wait_cycles = 0;
        while (n_pending != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (40) @(posedge i_clk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("barycentric_coordinates regression: pass");
        end else begin
            $display("barycentric_coordinates regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/bc_pkg.sv
sv/bc_dot.sv
sv/bc_mul.sv
sv/bc_div.sv
sv/barycentric_coordinates.sv
sv/bc_checker.sv
tb/barycentric_coordinates_checker.sv
tb/barycentric_coordinates_tb.sv
